FILE: rtl/core/infix_to_postfix_converter_core_macros.svh
// ------------------------------------------------------------------------
// Infix to postfix converter assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication.
`define ITP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("converter assertion failed");

// Next-cycle implication.
`define ITP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("converter assertion failed");

`endif

FILE: rtl/core/itp_pkg.sv
// ------------------------------------------------------------------------
// Infix to postfix converter package
// Shared constants, command and status types, and character decoding.
// ------------------------------------------------------------------------
package itp_pkg;

    // Operator stack geometry.
    localparam int STACK_DEPTH = 16;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Characters of interest.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;

    // Error codes.
    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_RPAR = 3'd1;
    localparam logic [2:0] ERR_LPAR = 3'd2;
    localparam logic [2:0] ERR_BAD  = 3'd3;
    localparam logic [2:0] ERR_OVF  = 3'd4;

    // Character classes.
    typedef logic [2:0] t_itp_cls;
    localparam t_itp_cls CLS_OPERAND = 3'd0;
    localparam t_itp_cls CLS_LPAR    = 3'd1;
    localparam t_itp_cls CLS_RPAR    = 3'd2;
    localparam t_itp_cls CLS_OPER    = 3'd3;
    localparam t_itp_cls CLS_BAD     = 3'd4;

    // Datapath operations.
    typedef logic [2:0] t_itp_op;
    localparam t_itp_op OP_NONE     = 3'd0;
    localparam t_itp_op OP_LOAD     = 3'd1;
    localparam t_itp_op OP_EMIT_CHR = 3'd2;
    localparam t_itp_op OP_PUSH     = 3'd3;
    localparam t_itp_op OP_POP_EMIT = 3'd4;
    localparam t_itp_op OP_POP_DROP = 3'd5;
    localparam t_itp_op OP_RAISE    = 3'd6;
    localparam t_itp_op OP_FINISH   = 3'd7;

    // Command from the controller to the datapath.
    typedef struct packed {
        t_itp_op    op;
        logic [2:0] err;
    } t_itp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_itp_cls cls;
        logic     stack_empty;
        logic     stack_full;
        logic     top_lpar;
        logic     pop_ok;
        logic     last;
        logic     out_free;
    } t_itp_status;

    // Classify one input character.
    function automatic t_itp_cls itp_class(input logic [7:0] c);
        t_itp_cls cls;
        if ((c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
            (c >= CH_D0 && c <= CH_D9)) begin
            cls = CLS_OPERAND;
        end else if (c == CH_LPAR) begin
            cls = CLS_LPAR;
        end else if (c == CH_RPAR) begin
            cls = CLS_RPAR;
        end else if (c == CH_PLUS || c == CH_MINUS || c == CH_MUL ||
                     c == CH_DIV || c == CH_POW) begin
            cls = CLS_OPER;
        end else begin
            cls = CLS_BAD;
        end
        return cls;
    endfunction

    // Operator precedence; zero for anything else, so '(' stops popping.
    function automatic logic [1:0] itp_prec(input logic [7:0] c);
        logic [1:0] p;
        if (c == CH_PLUS || c == CH_MINUS) begin
            p = 2'd1;
        end else if (c == CH_MUL || c == CH_DIV) begin
            p = 2'd2;
        end else if (c == CH_POW) begin
            p = 2'd3;
        end else begin
            p = 2'd0;
        end
        return p;
    endfunction

endpackage

FILE: rtl/core/itp_ctrl.sv
// ------------------------------------------------------------------------
// Infix to postfix converter controller
// Sequences one character at a time through execute, pop and flush steps.
// ------------------------------------------------------------------------
module itp_ctrl
    import itp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_itp_status i_status,
    output t_itp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_RPAR  = 3'd2;
    localparam logic [2:0] S_OPER  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [2:0] post_state;

    // After the character itself, an end-of-expression item flushes the stack.
    assign post_state = i_status.last ? S_FLUSH : S_DONE;
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state   = r_state;
        o_cmd.op  = OP_NONE;
        o_cmd.err = ERR_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.out_free) begin
                    case (i_status.cls)
                        CLS_OPERAND: begin
                            o_cmd.op = OP_EMIT_CHR;
                            n_state  = post_state;
                        end
                        CLS_LPAR: begin
                            if (i_status.stack_full) begin
                                o_cmd.op  = OP_RAISE;
                                o_cmd.err = ERR_OVF;
                            end else begin
                                o_cmd.op = OP_PUSH;
                            end
                            n_state = post_state;
                        end
                        CLS_RPAR: begin
                            n_state = S_RPAR;
                        end
                        CLS_OPER: begin
                            n_state = S_OPER;
                        end
                        default: begin
                            o_cmd.op  = OP_RAISE;
                            o_cmd.err = ERR_BAD;
                            n_state   = post_state;
                        end
                    endcase
                end
            end
            S_RPAR: begin
                if (i_status.out_free) begin
                    if (!i_status.stack_empty && !i_status.top_lpar) begin
                        o_cmd.op = OP_POP_EMIT;
                    end else if (!i_status.stack_empty) begin
                        o_cmd.op = OP_POP_DROP;
                        n_state  = post_state;
                    end else begin
                        o_cmd.op  = OP_RAISE;
                        o_cmd.err = ERR_RPAR;
                        n_state   = post_state;
                    end
                end
            end
            S_OPER: begin
                if (i_status.out_free) begin
                    if (!i_status.stack_empty && i_status.pop_ok) begin
                        o_cmd.op = OP_POP_EMIT;
                    end else if (i_status.stack_full) begin
                        o_cmd.op  = OP_RAISE;
                        o_cmd.err = ERR_OVF;
                        n_state   = post_state;
                    end else begin
                        o_cmd.op = OP_PUSH;
                        n_state  = post_state;
                    end
                end
            end
            S_FLUSH: begin
                if (i_status.out_free) begin
                    if (i_status.stack_empty) begin
                        n_state = S_DONE;
                    end else if (i_status.top_lpar) begin
                        o_cmd.op  = OP_POP_DROP;
                        o_cmd.err = ERR_LPAR;
                    end else begin
                        o_cmd.op = OP_POP_EMIT;
                    end
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/itp_dpath.sv
// ------------------------------------------------------------------------
// Infix to postfix converter datapath
// Operator stack memory, error state, pending result and output register.
// ------------------------------------------------------------------------
`include "infix_to_postfix_converter_core_macros.svh"

module itp_dpath
    import itp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_itp_cmd    i_cmd,
    input  logic [7:0]  i_in_char,
    input  logic        i_in_last,
    input  logic        i_out_ready,
    output t_itp_status o_status,
    output logic        o_out_valid,
    output logic [7:0]  o_out_char,
    output logic        o_out_cvalid,
    output logic        o_out_run_last,
    output logic        o_out_done,
    output logic [2:0]  o_out_err
);

    // Current item.
    logic [7:0]       r_char;
    logic             r_last;

    // Operator stack: memory plus a registered copy of the top entry.
    logic [7:0]       r_mem [STACK_DEPTH];
    logic [7:0]       r_top;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] n_cnt_m1;
    logic [IDX_W-1:0] rd_addr;

    // Error state.
    logic [2:0]       r_sticky;
    logic [2:0]       n_sticky;

    // Pending result, held until it is known whether it ends the item.
    logic             r_pend_valid;
    logic [7:0]       r_pend_char;
    logic             r_pend_cvalid;
    logic [2:0]       r_pend_err;

    // Output register.
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_cvalid;
    logic             r_out_run_last;
    logic             r_out_done;
    logic [2:0]       r_out_err;

    logic             out_free;
    logic             do_push;
    logic             do_pop;
    logic             produce;
    logic [7:0]       prod_char;
    logic             prod_cvalid;
    logic             set_err;
    logic             finish;

    assign out_free = !r_out_valid || i_out_ready;
    assign do_push  = (i_cmd.op == OP_PUSH);
    assign do_pop   = (i_cmd.op == OP_POP_EMIT) || (i_cmd.op == OP_POP_DROP);
    assign produce  = (i_cmd.op == OP_EMIT_CHR) || (i_cmd.op == OP_POP_EMIT) ||
                      (i_cmd.op == OP_RAISE);
    assign finish   = (i_cmd.op == OP_FINISH);

    // Status toward the controller.
    assign o_status.cls         = itp_class(r_char);
    assign o_status.stack_empty = (r_count == '0);
    assign o_status.stack_full  = (r_count == CNT_W'(STACK_DEPTH));
    assign o_status.top_lpar    = (r_top == CH_LPAR);
    assign o_status.pop_ok      = (itp_prec(r_char) <= itp_prec(r_top));
    assign o_status.last        = r_last;
    assign o_status.out_free    = out_free;

    // Stack depth update and the address of the next top entry.
    always_comb begin
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
        n_cnt_m1 = n_count - CNT_W'(1);
        rd_addr  = n_cnt_m1[IDX_W-1:0];
    end

    // Sticky error keeps the first error of the expression.
    always_comb begin
        set_err  = ((i_cmd.op == OP_RAISE) || (i_cmd.op == OP_POP_DROP)) &&
                   (i_cmd.err != ERR_NONE) && (r_sticky == ERR_NONE);
        n_sticky = r_sticky;
        if (set_err) begin
            n_sticky = i_cmd.err;
        end else if (finish && r_last) begin
            n_sticky = ERR_NONE;
        end
    end

    // Result produced this cycle.
    always_comb begin
        case (i_cmd.op)
            OP_EMIT_CHR: prod_char = r_char;
            OP_POP_EMIT: prod_char = r_top;
            default:     prod_char = 8'd0;
        endcase
        prod_cvalid = (i_cmd.op != OP_RAISE);
    end

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_char <= i_in_char;
            r_last <= i_in_last;
        end
    end

    // Stack memory write port.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_count[IDX_W-1:0]] <= r_char;
        end
    end

    // Stack memory read port; a push bypasses straight into the top copy.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_top <= r_char;
        end else begin
            r_top <= r_mem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sticky <= ERR_NONE;
        end else begin
            r_count  <= n_count;
            r_sticky <= n_sticky;
        end
    end

    // Pending result and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (produce) begin
                if (r_pend_valid) begin
                    r_out_valid    <= 1'b1;
                    r_out_char     <= r_pend_char;
                    r_out_cvalid   <= r_pend_cvalid;
                    r_out_run_last <= 1'b0;
                    r_out_done     <= 1'b0;
                    r_out_err      <= r_pend_err;
                end else if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
                r_pend_valid  <= 1'b1;
                r_pend_char   <= prod_char;
                r_pend_cvalid <= prod_cvalid;
                r_pend_err    <= n_sticky;
            end else if (finish && (r_pend_valid || r_last)) begin
                r_out_valid    <= 1'b1;
                r_out_char     <= r_pend_valid ? r_pend_char : 8'd0;
                r_out_cvalid   <= r_pend_valid && r_pend_cvalid;
                r_out_run_last <= 1'b1;
                r_out_done     <= r_last;
                r_out_err      <= r_last ? r_sticky : r_pend_err;
                r_pend_valid   <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_out_cvalid   = r_out_cvalid;
    assign o_out_run_last = r_out_run_last;
    assign o_out_done     = r_out_done;
    assign o_out_err      = r_out_err;

    // A result only moves on while the output register can take it.
    `ITP_ASSERT_IMP(a_move_needs_room, (produce && r_pend_valid) || finish, out_free)
    // The end of an expression is always the end of its item.
    `ITP_ASSERT_IMP(a_done_ends_run, r_out_valid && r_out_done, r_out_run_last)
    // Markers carry no character.
    `ITP_ASSERT_IMP(a_marker_blank, r_out_valid && !r_out_cvalid, r_out_char == 8'd0)
    // Finishing an expression leaves an empty stack and a clear error.
    `ITP_ASSERT_NEXT(a_expr_clean, finish && r_last,
                     (r_count == '0) && (r_sticky == ERR_NONE) && !r_pend_valid)

endmodule

FILE: rtl/core/infix_to_postfix_converter_core.sv
// Each character steps through accept, execute and finish; ')' or an operator adds a pop step
// before finish that pops operators off the stack one entry per cycle.
// A final character adds a flush step that pops each remaining stack entry; pops stall on the output.
// The last result of a character is offered on the output the cycle after it finishes.
// i_rst_n is synchronous, active low: it empties the stack and clears the error state.
// ------------------------------------------------------------------------
// Infix to postfix converter core
// Shunting-yard conversion of a character stream with an operator stack.
// ------------------------------------------------------------------------
module infix_to_postfix_converter_core
    import itp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // end_of_expr
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] char_out, [8] run_last, [11:9] error_code
    output logic        m_axis_tuser,   // [0] char_valid
    output logic        m_axis_tlast    // expr_done
);

    t_itp_cmd    cmd;
    t_itp_status status;
    logic [7:0]  out_char;
    logic        out_run_last;
    logic [2:0]  out_err;

    // Sequencer.
    itp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Stack, error state and result registers.
    itp_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_in_char      (s_axis_tdata),
        .i_in_last      (s_axis_tlast),
        .i_out_ready    (m_axis_tready),
        .o_status       (status),
        .o_out_valid    (m_axis_tvalid),
        .o_out_char     (out_char),
        .o_out_cvalid   (m_axis_tuser),
        .o_out_run_last (out_run_last),
        .o_out_done     (m_axis_tlast),
        .o_out_err      (out_err)
    );

    // Pack the result payload.
    assign m_axis_tdata = {4'b0000, out_err, out_run_last, out_char};

endmodule
